// ===== sv/sxe_pkg.sv =====
// ----------------------------------------------------------------------------
// SIC/XE execute package
// Shared payload types, codes and decode helpers of the SIC/XE execute block.
// ----------------------------------------------------------------------------
package sxe_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam int unsigned DATA_W = 24;

  // Item function codes.
  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_START = 2'd2;
  localparam logic [1:0] FN_STEP  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_BADOP = 2'd2;
  localparam logic [1:0] ST_DIV0  = 2'd3;

  // Condition code values held in SW.
  localparam logic [23:0] SW_LT = 24'h00003C;
  localparam logic [23:0] SW_EQ = 24'h00003D;
  localparam logic [23:0] SW_GT = 24'h00003E;

  // Condition code as reported.
  localparam logic [1:0] CC_LESS    = 2'd0;
  localparam logic [1:0] CC_EQUAL   = 2'd1;
  localparam logic [1:0] CC_GREATER = 2'd2;

  // Register numbers.
  localparam logic [3:0] R_A  = 4'd0;
  localparam logic [3:0] R_X  = 4'd1;
  localparam logic [3:0] R_L  = 4'd2;
  localparam logic [3:0] R_B  = 4'd3;
  localparam logic [3:0] R_S  = 4'd4;
  localparam logic [3:0] R_T  = 4'd5;
  localparam logic [3:0] R_PC = 4'd8;
  localparam logic [3:0] R_SW = 4'd9;
  localparam int unsigned NREGS = 10;

  // Instruction formats.
  localparam logic [1:0] FMT_NONE = 2'd0;
  localparam logic [1:0] FMT_1    = 2'd1;
  localparam logic [1:0] FMT_2    = 2'd2;
  localparam logic [1:0] FMT_34   = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [19:0] address;
    logic [7:0]  write_byte;
  } sxe_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic [23:0] pc_value;
    logic [23:0] acc_value;
    logic [23:0] index_value;
    logic [23:0] link_value;
    logic [23:0] base_value;
    logic [23:0] s_value;
    logic [23:0] t_value;
    logic [1:0]  cond_code;
  } sxe_out_t;

  typedef struct packed {
    logic [19:0] prog_start;
    logic [19:0] prog_length;
  } sxe_cfg_t;

  // Format of an opcode, indexed by the upper six bits of the first byte.
  function automatic logic [1:0] fmt_of(input logic [5:0] idx);
    logic [1:0] f;
    unique case (idx)
      6'd35, 6'd42, 6'd47, 6'd51, 6'd57, 6'd63: f = FMT_NONE;
      6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41,
      6'd43, 6'd44, 6'd45, 6'd46:               f = FMT_2;
      6'd48, 6'd49, 6'd50, 6'd60, 6'd61, 6'd62: f = FMT_1;
      default:                                  f = FMT_34;
    endcase
    return f;
  endfunction

endpackage

// ===== sv/sxe_bram.sv =====
// ----------------------------------------------------------------------------
// SIC/XE byte memory
// Single-port synchronous byte RAM with registered read data.
// ----------------------------------------------------------------------------
module sxe_bram #(
  parameter int unsigned MEM_BYTES = 65536,
  parameter int unsigned AW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [MEM_BYTES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

// ===== sv/sxe_amod.sv =====
// ----------------------------------------------------------------------------
// SIC/XE address reduction
// Reduces a 24-bit address modulo the memory size with a reciprocal multiply.
// ----------------------------------------------------------------------------
module sxe_amod import sxe_pkg::*; #(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [23:0]                  value_i,
  output logic                         valid_o,
  output logic [$clog2(MEM_BYTES)-1:0] addr_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam int unsigned RECIP = (1 << 24) / MEM_BYTES;
  localparam int unsigned RW = $clog2(RECIP + 1);
  localparam logic [24:0] MV = 25'(MEM_BYTES);

  logic [RW+23:0] prod;
  logic [RW-1:0]  q1_q;
  logic [23:0]    a1_q, a2_q, p2_q;
  logic [1:0]     vld_q;
  logic [24:0]    diff, red;

  // The estimated quotient is low by at most one, so one correction suffices.
  assign prod = value_i * RW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], go_i};
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q <= prod[RW+23:24];
    a1_q <= value_i;
    p2_q <= 24'(q1_q * MV);
    a2_q <= a1_q;
  end

  assign diff    = {1'b0, a2_q} - {1'b0, p2_q};
  assign red     = (diff >= MV) ? diff - MV : diff;
  assign addr_o  = red[AW-1:0];
  assign valid_o = vld_q[1];

endmodule

// ===== sv/sxe_div.sv =====
// ----------------------------------------------------------------------------
// SIC/XE divider
// Signed 24-bit truncating divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sxe_div import sxe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DATA_W);
  localparam logic [CW-1:0] LAST = CW'(DATA_W - 1);

  logic              run_q, done_q, neg_q;
  logic [CW-1:0]     cnt_q;
  logic [DATA_W-1:0] rem_q, quo_q, dvs_q;
  logic [DATA_W:0]   shifted;
  logic              fits;

  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      rem_q <= '0;
      quo_q <= dividend_i[DATA_W-1] ? -dividend_i : dividend_i;
      dvs_q <= divisor_i[DATA_W-1] ? -divisor_i : divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? DATA_W'(shifted - {1'b0, dvs_q}) : shifted[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -quo_q : quo_q;

endmodule

// ===== sv/sxe_core.sv =====
// ----------------------------------------------------------------------------
// SIC/XE execute core
// Sequencer, register file and execution around the byte memory.
// ----------------------------------------------------------------------------
module sxe_core import sxe_pkg::*; #(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  sxe_in_t  cmd_i,
  input  sxe_cfg_t cfg_i,
  output logic     busy_o,
  output logic     done_o,
  output sxe_out_t result_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [AW-1:0] LAST = AW'(MEM_BYTES - 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_AWAIT = 5'd1;
  localparam logic [4:0] S_MEMOP = 5'd2;
  localparam logic [4:0] S_RDB   = 5'd3;
  localparam logic [4:0] S_F0    = 5'd4;
  localparam logic [4:0] S_OP    = 5'd5;
  localparam logic [4:0] S_B1    = 5'd6;
  localparam logic [4:0] S_B2    = 5'd7;
  localparam logic [4:0] S_B3    = 5'd8;
  localparam logic [4:0] S_EA1   = 5'd9;
  localparam logic [4:0] S_EA2   = 5'd10;
  localparam logic [4:0] S_WRD   = 5'd11;
  localparam logic [4:0] S_X3    = 5'd12;
  localparam logic [4:0] S_STW   = 5'd13;
  localparam logic [4:0] S_F2A   = 5'd14;
  localparam logic [4:0] S_F2B   = 5'd15;
  localparam logic [4:0] S_X2    = 5'd16;
  localparam logic [4:0] S_DIVW  = 5'd17;
  localparam logic [4:0] S_DONE  = 5'd18;

  localparam logic [7:0] OP_LDA  = 8'h00;
  localparam logic [7:0] OP_LDX  = 8'h04;
  localparam logic [7:0] OP_LDL  = 8'h08;
  localparam logic [7:0] OP_STA  = 8'h0C;
  localparam logic [7:0] OP_STX  = 8'h10;
  localparam logic [7:0] OP_STL  = 8'h14;
  localparam logic [7:0] OP_ADD  = 8'h18;
  localparam logic [7:0] OP_SUB  = 8'h1C;
  localparam logic [7:0] OP_MUL  = 8'h20;
  localparam logic [7:0] OP_DIV  = 8'h24;
  localparam logic [7:0] OP_COMP = 8'h28;
  localparam logic [7:0] OP_TIX  = 8'h2C;
  localparam logic [7:0] OP_JEQ  = 8'h30;
  localparam logic [7:0] OP_JGT  = 8'h34;
  localparam logic [7:0] OP_JLT  = 8'h38;
  localparam logic [7:0] OP_J    = 8'h3C;
  localparam logic [7:0] OP_AND  = 8'h40;
  localparam logic [7:0] OP_OR   = 8'h44;
  localparam logic [7:0] OP_JSUB = 8'h48;
  localparam logic [7:0] OP_RSUB = 8'h4C;
  localparam logic [7:0] OP_LDCH = 8'h50;
  localparam logic [7:0] OP_STCH = 8'h54;
  localparam logic [7:0] OP_LDB  = 8'h68;
  localparam logic [7:0] OP_LDS  = 8'h6C;
  localparam logic [7:0] OP_LDT  = 8'h74;
  localparam logic [7:0] OP_STB  = 8'h78;
  localparam logic [7:0] OP_STS  = 8'h7C;
  localparam logic [7:0] OP_STT  = 8'h84;
  localparam logic [7:0] OP_TD   = 8'hE0;
  localparam logic [7:0] OP_STSW = 8'hE8;
  localparam logic [7:0] OP_ADDR = 8'h90;
  localparam logic [7:0] OP_SUBR = 8'h94;
  localparam logic [7:0] OP_MULR = 8'h98;
  localparam logic [7:0] OP_DIVR = 8'h9C;
  localparam logic [7:0] OP_COMPR = 8'hA0;
  localparam logic [7:0] OP_SHIFTL = 8'hA4;
  localparam logic [7:0] OP_RMO  = 8'hAC;
  localparam logic [7:0] OP_CLEAR = 8'hB4;
  localparam logic [7:0] OP_TIXR = 8'hB8;

  function automatic logic [23:0] cmp_code(input logic [23:0] a, input logic [23:0] b);
    logic [23:0] c;
    if (a == b) begin
      c = SW_EQ;
    end else if ($signed(a) < $signed(b)) begin
      c = SW_LT;
    end else begin
      c = SW_GT;
    end
    return c;
  endfunction

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  logic [4:0]    state_q, state_d, ret_q, ret_d;
  logic [23:0]   rf_q [NREGS];
  sxe_in_t       cmd_q, cmd_d;
  logic [7:0]    op_q, op_d, b1_q, b1_d, b2_q, b2_d, b3_q, b3_d;
  logic [23:0]   ta_q, ta_d, word_q, word_d, sdata_q, sdata_d;
  logic [23:0]   opa_q, opa_d, opb_q, opb_d;
  logic [AW-1:0] ptr_q, ptr_d, base_q, base_d;
  logic [1:0]    cnt_q, cnt_d, status_q, status_d;
  logic          ind_q, ind_d;
  logic [7:0]    rb_q, rb_d;
  logic [3:0]    dst_q, dst_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          amod_go, amod_vld;
  logic [23:0]   amod_val;
  logic [AW-1:0] amod_addr;
  logic          div_go, div_done;
  logic [23:0]   div_a, div_b, div_q;

  logic          wa_en, wb_en, clear_all;
  logic [3:0]    wa_idx, wb_idx, rsel;
  logic [23:0]   wa_data, wb_data, rd_val;

  logic [20:0]   prog_end;
  logic [23:0]   pc, acc, xr, sw;
  logic [1:0]    ni, fmt_n;
  logic [7:0]    opc;
  logic          xb, bb, pb;
  logic [23:0]   disp, npc, tsum, word_n, val, xn, tix_op;
  logic [2:0]    ilen;
  logic [4:0]    rot;
  logic [47:0]   rot_dbl;

  assign prog_end = {1'b0, cfg_i.prog_start} + {1'b0, cfg_i.prog_length};
  assign pc  = rf_q[R_PC];
  assign acc = rf_q[R_A];
  assign xr  = rf_q[R_X];
  assign sw  = rf_q[R_SW];
  assign ni  = op_q[1:0];
  assign opc = {op_q[7:2], 2'b00};
  assign xb  = b1_q[7];
  assign bb  = (ni != 2'd0) && b1_q[6];
  assign pb  = (ni != 2'd0) && b1_q[5];
  assign rd_val = (rsel < 4'(NREGS)) ? rf_q[rsel] : '0;
  assign word_n = {word_q[15:0], ram_rdata};
  assign val    = (ni == 2'd1) ? ta_q : word_q;
  assign xn     = xr + 24'd1;
  assign tix_op = (b1_q[7:4] == R_X) ? xn : opa_q;
  assign rot     = {1'b0, b1_q[3:0]} + 5'd1;
  assign rot_dbl = {opa_q, opa_q} << rot;

  // Target address: SIC-mode 15-bit address, format 3 displacement or format 4 address.
  always_comb begin
    fmt_n = fmt_of(ram_rdata[7:2]);
    if (ni == 2'd0) begin
      disp = {9'd0, b1_q[6:0], b2_q};
      ilen = 3'd3;
    end else if (b1_q[4]) begin
      disp = {4'd0, b1_q[3:0], b2_q, b3_q};
      ilen = 3'd4;
    end else begin
      disp = {12'd0, b1_q[3:0], b2_q};
      ilen = 3'd3;
      if (pb && !bb && b1_q[3]) begin
        disp[23:12] = '1;
      end
    end
    npc  = pc + 24'(ilen);
    tsum = ta_q + (bb ? rf_q[R_B] : (pb ? pc : 24'd0));
  end

  always_comb begin
    state_d = state_q; ret_d = ret_q; cmd_d = cmd_q;
    op_d = op_q; b1_d = b1_q; b2_d = b2_q; b3_d = b3_q;
    ta_d = ta_q; word_d = word_q; sdata_d = sdata_q;
    opa_d = opa_q; opb_d = opb_q; ptr_d = ptr_q; base_d = base_q;
    cnt_d = cnt_q; status_d = status_q; ind_d = ind_q; rb_d = rb_q; dst_d = dst_q;
    ram_we = 1'b0; ram_re = 1'b0; ram_addr = ptr_q; ram_wdata = '0;
    amod_go = 1'b0; amod_val = '0;
    div_go = 1'b0; div_a = '0; div_b = '0;
    wa_en = 1'b0; wa_idx = '0; wa_data = '0;
    wb_en = 1'b0; wb_idx = '0; wb_data = '0;
    clear_all = 1'b0;
    rsel = b1_q[7:4];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d    = cmd_i;
          rb_d     = '0;
          status_d = ST_OK;
          unique case (cmd_i.func)
            FN_WRITE, FN_READ: begin
              amod_go  = 1'b1;
              amod_val = {4'd0, cmd_i.address};
              ret_d    = S_MEMOP;
              state_d  = S_AWAIT;
            end
            FN_START: begin
              clear_all = 1'b1;
              state_d   = S_DONE;
            end
            default: begin
              if (pc >= {3'd0, prog_end}) begin
                status_d = ST_END;
                state_d  = S_DONE;
              end else begin
                amod_go  = 1'b1;
                amod_val = pc;
                ret_d    = S_F0;
                state_d  = S_AWAIT;
              end
            end
          endcase
        end
      end
      S_AWAIT: begin
        if (amod_vld) begin
          ptr_d   = amod_addr;
          base_d  = amod_addr;
          cnt_d   = '0;
          state_d = ret_q;
        end
      end
      S_MEMOP: begin
        if (cmd_q.func == FN_WRITE) begin
          ram_we    = 1'b1;
          ram_wdata = cmd_q.write_byte;
          state_d   = S_DONE;
        end else begin
          ram_re  = 1'b1;
          state_d = S_RDB;
        end
      end
      S_RDB: begin
        rb_d    = ram_rdata;
        state_d = S_DONE;
      end
      S_F0: begin
        ram_re  = 1'b1;
        ptr_d   = inc(ptr_q);
        state_d = S_OP;
      end
      S_OP: begin
        op_d = ram_rdata;
        if (ram_rdata == 8'd0 || fmt_n == FMT_1) begin
          wa_en = 1'b1; wa_idx = R_PC; wa_data = pc + 24'd1;
          state_d = S_DONE;
        end else if (fmt_n == FMT_NONE) begin
          status_d = ST_BADOP;
          state_d  = S_DONE;
        end else begin
          ram_re  = 1'b1;
          ptr_d   = inc(ptr_q);
          state_d = S_B1;
        end
      end
      S_B1: begin
        b1_d = ram_rdata;
        if (fmt_of(op_q[7:2]) == FMT_2) begin
          wa_en = 1'b1; wa_idx = R_PC; wa_data = pc + 24'd2;
          state_d = S_F2A;
        end else begin
          ram_re  = 1'b1;
          ptr_d   = inc(ptr_q);
          state_d = S_B2;
        end
      end
      S_B2: begin
        b2_d = ram_rdata;
        if (ni != 2'd0 && b1_q[4]) begin
          ram_re  = 1'b1;
          ptr_d   = inc(ptr_q);
          state_d = S_B3;
        end else begin
          state_d = S_EA1;
        end
      end
      S_B3: begin
        b3_d    = ram_rdata;
        state_d = S_EA1;
      end
      S_EA1: begin
        wa_en = 1'b1; wa_idx = R_PC; wa_data = npc;
        ta_d    = disp + (xb ? xr : 24'd0);
        state_d = S_EA2;
      end
      S_EA2: begin
        ta_d     = tsum;
        ind_d    = 1'b0;
        amod_go  = 1'b1;
        amod_val = tsum;
        ret_d    = S_WRD;
        state_d  = S_AWAIT;
      end
      S_WRD: begin
        // Three reads in flight back to back; each byte lands in the following cycle.
        if (cnt_q != 2'd3) begin
          ram_re = 1'b1;
          ptr_d  = inc(ptr_q);
        end
        if (cnt_q != 2'd0) begin
          word_d = word_n;
        end
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          cnt_d = '0;
          if (ni == 2'd2 && !ind_q) begin
            ta_d     = word_n;
            ind_d    = 1'b1;
            amod_go  = 1'b1;
            amod_val = word_n;
            ret_d    = S_WRD;
            state_d  = S_AWAIT;
          end else begin
            state_d = S_X3;
          end
        end
      end
      S_X3: begin
        state_d = S_DONE;
        ptr_d   = base_q;
        cnt_d   = '0;
        wa_idx  = R_A;
        unique case (opc)
          OP_ADD:  begin wa_en = 1'b1; wa_data = acc + val; end
          OP_SUB:  begin wa_en = 1'b1; wa_data = acc - val; end
          OP_MUL:  begin wa_en = 1'b1; wa_data = 24'(acc * val); end
          OP_AND:  begin wa_en = 1'b1; wa_data = acc & val; end
          OP_OR:   begin wa_en = 1'b1; wa_data = acc | val; end
          OP_LDA:  begin wa_en = 1'b1; wa_data = val; end
          OP_LDCH: begin
            wa_en   = 1'b1;
            wa_data = {acc[23:8], (ni == 2'd1) ? val[7:0] : val[23:16]};
          end
          OP_DIV: begin
            if (val == 24'd0) begin
              status_d = ST_DIV0;
            end else begin
              div_go = 1'b1; div_a = acc; div_b = val; dst_d = R_A;
              state_d = S_DIVW;
            end
          end
          OP_COMP: begin wa_en = 1'b1; wa_idx = R_SW; wa_data = cmp_code(acc, val); end
          OP_TIX: begin
            wa_en = 1'b1; wa_idx = R_X; wa_data = xn;
            wb_en = 1'b1; wb_idx = R_SW; wb_data = cmp_code(xn, val);
          end
          OP_J:    begin wa_en = 1'b1; wa_idx = R_PC; wa_data = ta_q; end
          OP_JEQ:  begin wa_en = (sw == SW_EQ); wa_idx = R_PC; wa_data = ta_q; end
          OP_JGT:  begin wa_en = (sw == SW_GT); wa_idx = R_PC; wa_data = ta_q; end
          OP_JLT:  begin wa_en = (sw == SW_LT); wa_idx = R_PC; wa_data = ta_q; end
          OP_JSUB: begin
            wa_en = 1'b1; wa_idx = R_L; wa_data = pc;
            wb_en = 1'b1; wb_idx = R_PC; wb_data = ta_q;
          end
          OP_RSUB: begin wa_en = 1'b1; wa_idx = R_PC; wa_data = rf_q[R_L]; end
          OP_LDB:  begin wa_en = 1'b1; wa_idx = R_B; wa_data = val; end
          OP_LDL:  begin wa_en = 1'b1; wa_idx = R_L; wa_data = val; end
          OP_LDS:  begin wa_en = 1'b1; wa_idx = R_S; wa_data = val; end
          OP_LDT:  begin wa_en = 1'b1; wa_idx = R_T; wa_data = val; end
          OP_LDX:  begin wa_en = 1'b1; wa_idx = R_X; wa_data = val; end
          OP_STA:  begin sdata_d = acc;         state_d = S_STW; end
          OP_STB:  begin sdata_d = rf_q[R_B];   state_d = S_STW; end
          OP_STL:  begin sdata_d = rf_q[R_L];   state_d = S_STW; end
          OP_STS:  begin sdata_d = rf_q[R_S];   state_d = S_STW; end
          OP_STSW: begin sdata_d = sw;          state_d = S_STW; end
          OP_STT:  begin sdata_d = rf_q[R_T];   state_d = S_STW; end
          OP_STX:  begin sdata_d = xr;          state_d = S_STW; end
          OP_STCH: begin
            ram_we = 1'b1; ram_addr = base_q; ram_wdata = acc[7:0];
          end
          OP_TD:   begin wa_en = 1'b1; wa_idx = R_SW; wa_data = SW_LT; end
          default: begin
          end
        endcase
      end
      S_STW: begin
        ram_we    = 1'b1;
        ram_wdata = sdata_q[23:16];
        sdata_d   = {sdata_q[15:0], 8'd0};
        ptr_d     = inc(ptr_q);
        cnt_d     = cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          state_d = S_DONE;
        end
      end
      S_F2A: begin
        rsel    = b1_q[7:4];
        opa_d   = rd_val;
        state_d = S_F2B;
      end
      S_F2B: begin
        rsel    = b1_q[3:0];
        opb_d   = rd_val;
        state_d = S_X2;
      end
      S_X2: begin
        state_d = S_DONE;
        wa_idx  = b1_q[3:0];
        unique case (opc)
          OP_ADDR: begin wa_en = 1'b1; wa_data = opb_q + opa_q; end
          OP_SUBR: begin wa_en = 1'b1; wa_data = opb_q - opa_q; end
          OP_MULR: begin wa_en = 1'b1; wa_data = 24'(opb_q * opa_q); end
          OP_DIVR: begin
            if (opa_q == 24'd0) begin
              status_d = ST_DIV0;
            end else begin
              div_go = 1'b1; div_a = opb_q; div_b = opa_q; dst_d = b1_q[3:0];
              state_d = S_DIVW;
            end
          end
          OP_COMPR: begin
            wa_en = 1'b1; wa_idx = R_SW; wa_data = cmp_code(opa_q, opb_q);
          end
          OP_SHIFTL: begin
            wa_en = 1'b1; wa_idx = b1_q[7:4]; wa_data = rot_dbl[47:24];
          end
          OP_RMO:   begin wa_en = 1'b1; wa_data = opa_q; end
          OP_CLEAR: begin wa_en = 1'b1; wa_idx = b1_q[7:4]; wa_data = '0; end
          OP_TIXR: begin
            wa_en = 1'b1; wa_idx = R_X; wa_data = xn;
            wb_en = 1'b1; wb_idx = R_SW; wb_data = cmp_code(xn, tix_op);
          end
          default: begin
          end
        endcase
      end
      S_DIVW: begin
        if (div_done) begin
          wa_en = 1'b1; wa_idx = dst_q; wa_data = div_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      for (int i = 0; i < NREGS; i++) begin
        rf_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (clear_all) begin
        for (int i = 0; i < NREGS; i++) begin
          rf_q[i] <= '0;
        end
        rf_q[R_PC] <= {4'd0, cfg_i.prog_start};
        rf_q[R_L]  <= {3'd0, prog_end};
      end else begin
        if (wa_en && wa_idx < 4'(NREGS)) begin
          rf_q[wa_idx] <= wa_data;
        end
        if (wb_en && wb_idx < 4'(NREGS)) begin
          rf_q[wb_idx] <= wb_data;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; op_q <= op_d; b1_q <= b1_d; b2_q <= b2_d; b3_q <= b3_d;
    ta_q <= ta_d; word_q <= word_d; sdata_q <= sdata_d;
    opa_q <= opa_d; opb_q <= opb_d; ptr_q <= ptr_d; base_q <= base_d;
    cnt_q <= cnt_d; status_q <= status_d; ind_q <= ind_d; rb_q <= rb_d;
    dst_q <= dst_d;
  end

  sxe_bram #(.MEM_BYTES(MEM_BYTES), .AW(AW)) u_bram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  sxe_amod #(.MEM_BYTES(MEM_BYTES)) u_amod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (amod_go),
    .value_i (amod_val),
    .valid_o (amod_vld),
    .addr_o  (amod_addr)
  );

  sxe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  always_comb begin
    result_o.status      = status_q;
    result_o.read_byte   = rb_q;
    result_o.pc_value    = pc;
    result_o.acc_value   = acc;
    result_o.index_value = xr;
    result_o.link_value  = rf_q[R_L];
    result_o.base_value  = rf_q[R_B];
    result_o.s_value     = rf_q[R_S];
    result_o.t_value     = rf_q[R_T];
    if (sw == SW_EQ) begin
      result_o.cond_code = CC_EQUAL;
    end else if (sw == SW_GT) begin
      result_o.cond_code = CC_GREATER;
    end else begin
      result_o.cond_code = CC_LESS;
    end
  end

endmodule

// ===== sv/sicxe_instruction_execute_top.sv =====
// The sequencer handles one item at a time; the next transfer is taken in the cycle
// after the result strobe. The divider (one bit per cycle) and the byte-wide memory
// port set how long a step takes.
// Reset clears the registers and configuration; the byte memory is not cleared.
// ----------------------------------------------------------------------------
// SIC/XE instruction execute
// Integer SIC/XE core with a private byte memory, configured over APB.
// ----------------------------------------------------------------------------
module sicxe_instruction_execute_top import sxe_pkg::*; #(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  sxe_in_t     cmd_i,
  output logic        done_o,
  output sxe_out_t    result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers: program start at byte 0, program length at byte 4.
  // Address bit 2 alone selects the register.
  sxe_cfg_t cfg_q;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        cfg_q.prog_length <= pwdata[19:0];
      end else begin
        cfg_q.prog_start <= pwdata[19:0];
      end
    end
  end

  assign prdata = paddr[2] ? {12'd0, cfg_q.prog_length} : {12'd0, cfg_q.prog_start};

  // The core accepts a transfer only while it is not busy; the result strobe
  // lasts one cycle and cannot be stalled by the receiver.
  sxe_core #(.MEM_BYTES(MEM_BYTES)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start && !busy),
    .cmd_i    (cmd_i),
    .cfg_i    (cfg_q),
    .busy_o   (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transfer did not raise busy");

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe outside a busy window");

  a_cc_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.cond_code != 2'd3)) else $error("invalid condition code");
`endif

endmodule
